/* rtl/dns_response_a_record_parser_assert.svh */
// Assertion macros for the DNS A-record parser checker.
`ifndef DNS_RESPONSE_A_RECORD_PARSER_ASSERT_SVH
`define DNS_RESPONSE_A_RECORD_PARSER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define DNS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define DNS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dns_pkg.sv */
// ----------------------------------------------------------------------------
// dns_pkg
// Shared constants, codes and types of the DNS reply A-record parser.
// ----------------------------------------------------------------------------
package dns_pkg;

    localparam int unsigned MaxBytes  = 512;
    localparam int unsigned MaxLabels = 32;
    localparam int unsigned PosW      = 10;
    localparam logic [16:0] TtlMax    = 17'd86400;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_SHORT    = 4'd1;
    localparam logic [3:0] ST_BAD_ID   = 4'd2;
    localparam logic [3:0] ST_NOT_RESP = 4'd3;
    localparam logic [3:0] ST_RC_OTHER = 4'd9;
    localparam logic [3:0] ST_BAD_Q    = 4'd10;
    localparam logic [3:0] ST_BAD_AN   = 4'd11;
    localparam logic [3:0] ST_BAD_RD   = 4'd12;
    localparam logic [3:0] ST_NO_A     = 4'd13;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] expected_id;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] address;
        logic [16:0] ttl_seconds;
        logic [15:0] an_count;
    } t_out_beat;

endpackage

/* rtl/dns_if.sv */
// ----------------------------------------------------------------------------
// dns_in_if / dns_out_if
// Valid/ready channels carrying packet bytes and parse results.
// ----------------------------------------------------------------------------
interface dns_in_if;
    logic              valid;
    logic              ready;
    dns_pkg::t_in_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface dns_out_if;
    logic               valid;
    logic               ready;
    dns_pkg::t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/dns_parse_core.sv */
// ----------------------------------------------------------------------------
// dns_parse_core
// Per-byte parser state; raises a result beat at most once per packet.
// ----------------------------------------------------------------------------
module dns_parse_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  dns_pkg::t_in_beat  i_beat,
    output logic               o_res_vld,
    output dns_pkg::t_out_beat o_res
);
    typedef enum logic [2:0] {
        PH_HEADER, PH_NAME, PH_LABEL, PH_PTR, PH_FIXED, PH_ADATA, PH_SKIP, PH_DONE
    } t_phase;

    t_phase      r_ph, n_ph;
    logic [9:0]  r_pos, n_pos;
    logic [15:0] r_flags, n_flags, r_ql, n_ql, r_al, n_al, r_at, n_at, r_rd, n_rd;
    logic        r_idm, n_idm, r_sent, n_sent;
    logic [5:0]  r_lbl, n_lbl;
    logic [6:0]  r_ls, n_ls;
    logic [3:0]  r_fi, n_fi;
    logic [63:0] r_rf, n_rf;
    logic [31:0] r_addr, n_addr;

    logic [7:0] b;
    logic       fin, in_q, nm_done;
    logic [3:0] st;
    logic [3:0] rc;
    logic [15:0] al_dec;

    always_comb begin
        b = i_beat.data_byte;
        n_ph = r_ph; n_pos = r_pos; n_flags = r_flags; n_ql = r_ql; n_al = r_al;
        n_at = r_at; n_rd = r_rd; n_idm = r_idm; n_sent = r_sent; n_lbl = r_lbl;
        n_ls = r_ls; n_fi = r_fi; n_rf = r_rf; n_addr = r_addr;
        fin = 1'b0; st = dns_pkg::ST_OK; nm_done = 1'b0;
        in_q = (r_ql != 16'd0);
        rc = r_flags[3:0];
        al_dec = r_al - 16'd1;
        o_res = '0;
        if (i_en && !r_sent) begin
            unique case (r_ph)
                PH_HEADER: begin
                    unique case (r_pos[3:0])
                        4'd0: n_idm = (b == i_beat.expected_id[15:8]);
                        4'd1: n_idm = r_idm & (b == i_beat.expected_id[7:0]);
                        4'd2, 4'd3: n_flags = {r_flags[7:0], b};
                        4'd4, 4'd5: n_ql = {r_ql[7:0], b};
                        4'd6, 4'd7: n_al = {r_al[7:0], b};
                        default: ;
                    endcase
                    if (r_pos == 10'd11) begin
                        if (!r_idm) begin
                            fin = 1'b1; st = dns_pkg::ST_BAD_ID;
                        end else if (!r_flags[15]) begin
                            fin = 1'b1; st = dns_pkg::ST_NOT_RESP;
                        end else if (rc != 4'd0) begin
                            fin = 1'b1;
                            st = (rc <= 4'd5) ? rc + 4'd3 : dns_pkg::ST_RC_OTHER;
                        end else begin
                            n_at = r_al;
                            if (r_ql == 16'd0 && r_al == 16'd0) begin
                                fin = 1'b1; st = dns_pkg::ST_NO_A;
                            end else begin
                                n_ph = PH_NAME; n_ls = '0; n_lbl = '0;
                            end
                        end
                    end
                end
                PH_PTR: nm_done = 1'b1;
                PH_LABEL: begin
                    n_lbl = r_lbl - 6'd1;
                    if (r_lbl == 6'd1) n_ph = PH_NAME;
                end
                PH_NAME: begin
                    if (b == 8'd0) nm_done = 1'b1;
                    else if (b[7:6] == 2'b11) n_ph = PH_PTR;
                    else if (b[7:6] != 2'b00 ||
                             32'(r_ls) + 32'd1 >= 32'(dns_pkg::MaxLabels)) begin
                        fin = 1'b1; st = in_q ? dns_pkg::ST_BAD_Q : dns_pkg::ST_BAD_AN;
                    end else begin
                        n_ls = r_ls + 7'd1; n_lbl = b[5:0]; n_ph = PH_LABEL;
                    end
                end
                PH_FIXED: begin
                    if (r_fi < 4'd8) n_rf = {r_rf[55:0], b};
                    else n_rd = {r_rd[7:0], b};
                    n_fi = r_fi + 4'd1;
                    if (in_q) begin
                        if (r_fi == 4'd3) begin
                            n_ql = r_ql - 16'd1;
                            if (r_ql == 16'd1 && r_al == 16'd0) begin
                                fin = 1'b1; st = dns_pkg::ST_NO_A;
                            end else begin
                                n_ph = PH_NAME; n_ls = '0; n_lbl = '0;
                            end
                        end
                    end else if (r_fi == 4'd9) begin
                        // type sits in the top two bytes, class below it
                        if (r_rf[63:48] == 16'd1 && r_rf[47:32] == 16'd1 &&
                            {r_rd[7:0], b} == 16'd4) begin
                            n_ph = PH_ADATA; n_addr = '0;
                        end else if ({r_rd[7:0], b} == 16'd0) begin
                            n_al = al_dec;
                            if (al_dec == 16'd0) begin
                                fin = 1'b1; st = dns_pkg::ST_NO_A;
                            end else begin
                                n_ph = PH_NAME; n_ls = '0; n_lbl = '0;
                            end
                        end else n_ph = PH_SKIP;
                    end
                end
                PH_ADATA: begin
                    n_addr = {r_addr[23:0], b};
                    n_rd = r_rd - 16'd1;
                    if (r_rd == 16'd1) begin
                        fin = 1'b1; st = dns_pkg::ST_OK;
                    end
                end
                PH_SKIP: begin
                    n_rd = r_rd - 16'd1;
                    if (r_rd == 16'd1) begin
                        n_al = al_dec;
                        if (al_dec == 16'd0) begin
                            fin = 1'b1; st = dns_pkg::ST_NO_A;
                        end else begin
                            n_ph = PH_NAME; n_ls = '0; n_lbl = '0;
                        end
                    end
                end
                PH_DONE: ;
                default: ;
            endcase
            if (nm_done) begin
                n_ph = PH_FIXED; n_fi = '0; n_rf = '0; n_rd = '0;
            end
            if (!fin && (i_beat.last_byte ||
                         32'(r_pos) + 32'd1 >= 32'(dns_pkg::MaxBytes))) begin
                fin = 1'b1;
                case (n_ph)
                    PH_HEADER: st = dns_pkg::ST_SHORT;
                    PH_ADATA, PH_SKIP: st = dns_pkg::ST_BAD_RD;
                    default: st = (n_ql != 16'd0) ? dns_pkg::ST_BAD_Q : dns_pkg::ST_BAD_AN;
                endcase
            end
            n_pos = r_pos + 10'd1;
            if (fin) begin
                n_sent = 1'b1; n_ph = PH_DONE;
                o_res.status = st;
                if (st == dns_pkg::ST_OK) begin
                    o_res.address = n_addr;
                    o_res.ttl_seconds = (r_rf[31:0] > 32'(dns_pkg::TtlMax)) ?
                        dns_pkg::TtlMax : r_rf[16:0];
                    o_res.an_count = r_at;
                end
            end
        end
        o_res_vld = fin;
        if (i_en && i_beat.last_byte) begin
            n_ph = PH_HEADER; n_pos = '0; n_flags = '0; n_idm = 1'b0; n_ql = '0;
            n_al = '0; n_at = '0; n_lbl = '0; n_ls = '0; n_fi = '0; n_rf = '0;
            n_rd = '0; n_addr = '0; n_sent = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_HEADER; r_pos <= '0; r_flags <= '0; r_idm <= 1'b0; r_ql <= '0;
            r_al <= '0; r_at <= '0; r_lbl <= '0; r_ls <= '0; r_fi <= '0; r_rf <= '0;
            r_rd <= '0; r_addr <= '0; r_sent <= 1'b0;
        end else begin
            r_ph <= n_ph; r_pos <= n_pos; r_flags <= n_flags; r_idm <= n_idm;
            r_ql <= n_ql; r_al <= n_al; r_at <= n_at; r_lbl <= n_lbl; r_ls <= n_ls;
            r_fi <= n_fi; r_rf <= n_rf; r_rd <= n_rd; r_addr <= n_addr;
            r_sent <= n_sent;
        end
    end
endmodule

/* rtl/dns_out_reg.sv */
// ----------------------------------------------------------------------------
// dns_out_reg
// Result register with a skid slot so input can flow during a stall.
// ----------------------------------------------------------------------------
module dns_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  dns_pkg::t_out_beat i_res,
    output logic               o_space,
    dns_out_if.source          out
);
    logic               r_v0, r_v1;
    dns_pkg::t_out_beat r_d0, r_d1;

    // Room exists unless both slots full.
    assign o_space   = !r_v1;
    assign out.valid = r_v0;
    assign out.payload = r_d0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_v1 <= 1'b0;
        end else begin
            if (!r_v0 || out.ready) begin
                if (r_v1) begin
                    r_v0 <= 1'b1; r_d0 <= r_d1; r_v1 <= i_vld; r_d1 <= i_res;
                end else begin
                    r_v0 <= i_vld; r_d0 <= i_res;
                end
            end else if (i_vld) begin
                r_v1 <= 1'b1; r_d1 <= i_res;
            end
        end
    end
endmodule

/* rtl/dns_response_a_record_parser.sv */
// ----------------------------------------------------------------------------
// dns_response_a_record_parser
// DNS reply parser that yields the first A record of a packet.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one packet byte per beat with last_byte and the query id.
//   o_out carries one result beat per packet: status, address, TTL and
//   answer count.
//   Throughput: one byte per cycle while the result buffer has room. The
//   parser state updates per byte; the result beat is registered in the output buffer.
//   Bytes after the result, or past 512 bytes, are consumed and dropped
//   until last_byte.
//   Reset: all parser state clears and the next byte is a header byte.
//   Stall: a two-entry result buffer absorbs a waiting result; input is held
//   off only while both entries are occupied.
// ----------------------------------------------------------------------------
module dns_response_a_record_parser (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dns_in_if.sink    i_in,
    dns_out_if.source o_out
);
    logic               space, en, res_vld;
    dns_pkg::t_out_beat res;

    assign i_in.ready = space;
    assign en = i_in.valid && space;

    dns_parse_core u_core (
        .i_clk, .i_rst_n, .i_en(en), .i_beat(i_in.payload),
        .o_res_vld(res_vld), .o_res(res)
    );

    dns_out_reg u_out (
        .i_clk, .i_rst_n, .i_vld(res_vld), .i_res(res), .o_space(space), .out(o_out)
    );
endmodule

/* rtl/dns_checker.sv */
// ----------------------------------------------------------------------------
// dns_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "dns_response_a_record_parser_assert.svh"

module dns_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input dns_pkg::t_out_beat out_payload
);
    `DNS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_payload), "result dropped while stalled")
    `DNS_ASSERT_IMPL(a_ok_fields, i_clk, i_rst_n, out_valid && out_payload.status != dns_pkg::ST_OK, out_payload.address == '0 && out_payload.ttl_seconds == '0 && out_payload.an_count == '0, "error result carries data")
    `DNS_ASSERT_IMPL(a_ttl, i_clk, i_rst_n, out_valid, out_payload.ttl_seconds <= dns_pkg::TtlMax && out_payload.status <= dns_pkg::ST_NO_A, "result out of range")
    `DNS_ASSERT_IMPL(a_ready, i_clk, i_rst_n, !in_ready, out_valid, "input blocked with no pending result")
endmodule

bind dns_response_a_record_parser dns_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready), .out_payload(o_out.payload)
);
